// ===== rtl/ebra_pkg.sv =====
package ebra_pkg;

  // register file geometry
  localparam int NumRegs  = 16;
  localparam int RegIdxW  = 4;
  localparam int DataW    = 8;
  localparam int OpW      = 5;

  localparam logic [RegIdxW-1:0] FlagIdx = 4'hF;
  localparam logic [DataW-1:0]   MsbMask = 8'h80;
  localparam logic [DataW-1:0]   ByteMax = 8'd255;

  // operation codes
  typedef enum logic [OpW-1:0] {
    OpCopy = 5'd0,
    OpOr   = 5'd1,
    OpAnd  = 5'd2,
    OpXor  = 5'd3,
    OpAdd  = 5'd4,
    OpSub  = 5'd5,
    OpShr  = 5'd6,
    OpSubn = 5'd7,
    OpShl  = 5'd14,
    OpLoad = 5'd16
  } op_e;

  // what the alu decides for one item
  typedef struct packed {
    logic [DataW-1:0] res;
    logic [DataW-1:0] flag;
    logic             wr_x;
    logic             wr_flag;
    logic             known;
  } alu_res_t;

endpackage

// ===== rtl/ebra_ram.sv =====
module ebra_ram #(
  parameter int Width = 8,
  parameter int Depth = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  // write port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // registered read port, old data on a same-address write
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ===== rtl/ebra_alu.sv =====
module ebra_alu import ebra_pkg::*; (
  input  logic [OpW-1:0]   op_i,
  input  logic [DataW-1:0] vx_i,
  input  logic [DataW-1:0] vy_i,
  input  logic [DataW-1:0] ld_i,
  input  logic             legacy_i,
  output alu_res_t         res_o
);

  logic [DataW:0]   sum;
  logic [DataW-1:0] shift_src;

  assign sum       = {1'b0, vx_i} + {1'b0, vy_i};
  assign shift_src = legacy_i ? vy_i : vx_i;

  // operation decode and datapath
  always_comb begin
    res_o.res     = vx_i;
    res_o.flag    = '0;
    res_o.wr_x    = 1'b1;
    res_o.wr_flag = 1'b1;
    res_o.known   = 1'b1;
    case (op_i)
      OpCopy: begin
        res_o.res     = vy_i;
        res_o.wr_flag = 1'b0;
      end
      OpOr: begin
        res_o.res     = vx_i | vy_i;
        res_o.wr_flag = legacy_i;
      end
      OpAnd: begin
        res_o.res     = vx_i & vy_i;
        res_o.wr_flag = legacy_i;
      end
      OpXor: begin
        res_o.res     = vx_i ^ vy_i;
        res_o.wr_flag = legacy_i;
      end
      OpAdd: begin
        res_o.res  = sum[DataW-1:0];
        res_o.flag = {{(DataW-1){1'b0}}, sum > {1'b0, ByteMax}};
      end
      OpSub: begin
        res_o.res  = vx_i - vy_i;
        res_o.flag = {{(DataW-1){1'b0}}, vy_i <= vx_i};
      end
      OpShr: begin
        res_o.res  = shift_src >> 1;
        res_o.flag = {{(DataW-1){1'b0}}, shift_src[0]};
      end
      OpSubn: begin
        res_o.res  = vy_i - vx_i;
        res_o.flag = {{(DataW-1){1'b0}}, vx_i <= vy_i};
      end
      OpShl: begin
        res_o.res  = shift_src << 1;
        res_o.flag = {{(DataW-1){1'b0}}, (shift_src & MsbMask) != '0};
      end
      OpLoad: begin
        res_o.res     = ld_i;
        res_o.wr_flag = 1'b0;
      end
      default: begin
        res_o.wr_x    = 1'b0;
        res_o.wr_flag = 1'b0;
        res_o.known   = 1'b0;
      end
    endcase
  end

endmodule

// ===== rtl/eight_bit_register_alu_top.sv =====
// channel | signals                                   | direction
// --------+-------------------------------------------+----------
// in      | in_valid_i/in_ready_o, operation_i,       | input
//         | reg_x_i, reg_y_i, load_value_i            |
// out     | out_valid_o/out_ready_i, x_value_o,       | output
//         | flag_value_o, recognized_o                |
// cfg     | legacy_mode_we_i, legacy_mode_i           | input
//
// one item per cycle while the output is not stalled; the result passes the register read
// in the two ram copies at accept, then alu and write-back into the output register.
// a write feeding the next item's read is forwarded from a last-write register.
// reset clears the entry valid bits at once, so no clearing pass is needed.
// a stalled output holds the alu stage, and in_ready_o drops only then.
module eight_bit_register_alu_top import ebra_pkg::*; #(
  parameter int NUM_REGS = NumRegs
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               legacy_mode_we_i,
  input  logic               legacy_mode_i,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  logic [OpW-1:0]     operation_i,
  input  logic [RegIdxW-1:0] reg_x_i,
  input  logic [RegIdxW-1:0] reg_y_i,
  input  logic [DataW-1:0]   load_value_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output logic [DataW-1:0]   x_value_o,
  output logic [DataW-1:0]   flag_value_o,
  output logic               recognized_o
);

  logic legacy_q;

  logic               s1_valid_q;
  logic [OpW-1:0]     s1_op_q;
  logic [RegIdxW-1:0] s1_x_q;
  logic [RegIdxW-1:0] s1_y_q;
  logic [DataW-1:0]   s1_ld_q;

  logic               lw_valid_q;
  logic [RegIdxW-1:0] lw_addr_q;
  logic [DataW-1:0]   lw_data_q;

  logic [NUM_REGS-1:0] vld_q;
  logic [DataW-1:0]    vf_q;
  logic [DataW-1:0]    vf_d;

  logic               out_valid_q;
  logic [DataW-1:0]   x_value_q;
  logic [DataW-1:0]   flag_value_q;
  logic               recognized_q;
  logic [DataW-1:0]   x_value_d;

  logic             in_accept;
  logic             s1_adv;
  logic [DataW-1:0] ram_x_rd;
  logic [DataW-1:0] ram_y_rd;
  logic [DataW-1:0] vx;
  logic [DataW-1:0] vy;
  logic             ram_we;
  alu_res_t         alu_res;

  // handshake
  assign s1_adv     = s1_valid_q && (!out_valid_q || out_ready_i);
  assign in_ready_o = !s1_valid_q || s1_adv;
  assign in_accept  = in_valid_i && in_ready_o;

  // configuration register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      legacy_q <= 1'b1;
    end else if (legacy_mode_we_i) begin
      legacy_q <= legacy_mode_i;
    end
  end

  // two copies of the register file, one read port each
  ebra_ram #(.Width(DataW), .Depth(NUM_REGS)) u_ram_x (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (s1_x_q),
    .wdata_i (alu_res.res),
    .re_i    (in_accept),
    .raddr_i (reg_x_i),
    .rdata_o (ram_x_rd)
  );

  ebra_ram #(.Width(DataW), .Depth(NUM_REGS)) u_ram_y (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (s1_x_q),
    .wdata_i (alu_res.res),
    .re_i    (in_accept),
    .raddr_i (reg_y_i),
    .rdata_o (ram_y_rd)
  );

  // read stage register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (in_accept) begin
      s1_valid_q <= 1'b1;
    end else if (s1_adv) begin
      s1_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      s1_op_q <= operation_i;
      s1_x_q  <= reg_x_i;
      s1_y_q  <= reg_y_i;
      s1_ld_q <= load_value_i;
    end
  end

  // operand select: flag flop, forwarded write, unwritten entry, ram
  always_comb begin
    if (s1_x_q == FlagIdx) begin
      vx = vf_q;
    end else if (lw_valid_q && lw_addr_q == s1_x_q) begin
      vx = lw_data_q;
    end else if (vld_q[s1_x_q]) begin
      vx = ram_x_rd;
    end else begin
      vx = '0;
    end
    if (s1_y_q == FlagIdx) begin
      vy = vf_q;
    end else if (lw_valid_q && lw_addr_q == s1_y_q) begin
      vy = lw_data_q;
    end else if (vld_q[s1_y_q]) begin
      vy = ram_y_rd;
    end else begin
      vy = '0;
    end
  end

  ebra_alu u_alu (
    .op_i     (s1_op_q),
    .vx_i     (vx),
    .vy_i     (vy),
    .ld_i     (s1_ld_q),
    .legacy_i (legacy_q),
    .res_o    (alu_res)
  );

  // write-back; the flag register lives in a flop, the flag write wins
  assign ram_we = s1_adv && alu_res.wr_x && (s1_x_q != FlagIdx);

  always_comb begin
    if (alu_res.wr_flag) begin
      vf_d = alu_res.flag;
    end else if (alu_res.wr_x && s1_x_q == FlagIdx) begin
      vf_d = alu_res.res;
    end else begin
      vf_d = vf_q;
    end
    if (s1_x_q == FlagIdx) begin
      x_value_d = vf_d;
    end else if (alu_res.wr_x) begin
      x_value_d = alu_res.res;
    end else begin
      x_value_d = vx;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vf_q       <= '0;
      vld_q      <= '0;
      lw_valid_q <= 1'b0;
    end else begin
      if (s1_adv) begin
        vf_q <= vf_d;
      end
      if (ram_we) begin
        vld_q[s1_x_q] <= 1'b1;
        lw_valid_q    <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (ram_we) begin
      lw_addr_q <= s1_x_q;
      lw_data_q <= alu_res.res;
    end
  end

  // output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (s1_adv) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_adv) begin
      x_value_q    <= x_value_d;
      flag_value_q <= vf_d;
      recognized_q <= alu_res.known;
    end
  end

  assign out_valid_o  = out_valid_q;
  assign x_value_o    = x_value_q;
  assign flag_value_o = flag_value_q;
  assign recognized_o = recognized_q;

  // checks
  a_adv_gives_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s1_adv |=> out_valid_o)
    else $error("alu stage advanced without a result");

  a_ram_no_flag: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ram_we |-> (s1_x_q != FlagIdx))
    else $error("flag register written into ram");

  a_stage_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s1_valid_q && !s1_adv) |=> (s1_valid_q && $stable(s1_x_q) && $stable(s1_op_q)))
    else $error("stalled alu stage lost its item");

  a_flag_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s1_adv |=> (flag_value_o == vf_q))
    else $error("reported flag differs from flag register");

endmodule
